// File: rtl/stereo_linear_resampler_assert.svh
// assertion macros used by the resampler checker
`ifndef STEREO_LINEAR_RESAMPLER_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SLR_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("stereo_linear_resampler: check failed");

// consequent must hold in the cycle after the antecedent
`define SLR_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("stereo_linear_resampler: check failed");

`endif

// File: rtl/slr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int MAX_OUT             = 16;
  localparam int CNT_W               = $clog2(MAX_OUT + 1);

  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 18;
  localparam int PITCH_W    = 20;
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 14;
  localparam int PITCH_FRAC = 16;
  localparam int PHASE_INT  = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_GAIN = 1'b1;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 20'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic issue;
    logic finish;
    logic last;
  } slr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic have_prev;
    logic phase_lt_one;
    logic next_lt_one;
    logic can_issue;
  } slr_sts_t;

endpackage

`default_nettype wire

// File: rtl/slr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_restart,
  output logic                  in_ready,
  input  wire slr_pkg::slr_sts_t sts,
  output slr_pkg::slr_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } slr_state_t;

  slr_state_t                  state_r, state_nxt;
  logic [slr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        more;

  assign in_ready = (state_r == ST_IDLE);
  assign more     = (cnt_r < slr_pkg::CNT_W'(slr_pkg::MAX_OUT)) && sts.phase_lt_one;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          // first frame or restart only primes the history
          if (!in_restart && sts.have_prev) begin
            state_nxt = ST_RUN;
            cnt_nxt   = '0;
          end
        end
      end
      ST_RUN: begin
        if (more) begin
          if (sts.can_issue) begin
            cmd.issue = 1'b1;
            cmd.last  = (cnt_r == slr_pkg::CNT_W'(slr_pkg::MAX_OUT - 1)) ||
                        !sts.next_lt_one;
            cnt_nxt   = cnt_r + 1'b1;
          end
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/slr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_datapath #(
  parameter int PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [slr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]   in_left_in,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]   in_right_in,
  input  wire logic                                  in_restart,
  input  wire slr_pkg::slr_cmd_t                     cmd,
  output slr_pkg::slr_sts_t                          sts,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [slr_pkg::OUT_W-1:0]           out_left_out,
  output logic signed [slr_pkg::OUT_W-1:0]           out_right_out,
  output logic                                       out_last_of_run
);

  localparam int P         = PHASE_FRAC_BITS;
  localparam int SW        = slr_pkg::SAMPLE_W;
  localparam int PHASE_W   = P + slr_pkg::PHASE_INT;
  localparam int STEP_W    = P + slr_pkg::PHASE_INT - 1;
  localparam int STEP_UP   = (P > slr_pkg::PITCH_FRAC) ? (P - slr_pkg::PITCH_FRAC) : 0;
  localparam int STEP_DOWN = (P < slr_pkg::PITCH_FRAC) ? (slr_pkg::PITCH_FRAC - P) : 0;
  localparam int WIDE_W    = slr_pkg::PITCH_W + STEP_UP;
  localparam int PROD_W    = SW + 1 + P + 1;
  localparam int ACC_W     = PROD_W;
  localparam int GP_W      = SW + slr_pkg::GAIN_W + 1;
  localparam int GS        = slr_pkg::GAIN_SHIFT;
  localparam int OW        = slr_pkg::OUT_W;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << P;

  // configuration
  logic [slr_pkg::PITCH_W-1:0] pitch_r;
  logic [slr_pkg::GAIN_W-1:0]  gain_r;

  // frame history and phase
  logic signed [SW-1:0] prev_l_r, prev_r_r, cur_l_r, cur_r_r;
  logic [PHASE_W-1:0]   phase_r;
  logic                 have_r;

  logic [WIDE_W-1:0]    step_wide;
  logic [STEP_W-1:0]    step;
  logic [PHASE_W-1:0]   phase_sum;

  // pipeline
  logic                     va_r, vb_r, vc_r;
  logic                     last_a_r, last_b_r, last_c_r;
  logic signed [SW-1:0]     base_l_r, base_r_r;
  logic signed [PROD_W-1:0] prod_l_r, prod_r_r;
  logic signed [SW-1:0]     s_l_r, s_r_r;
  logic signed [GP_W-1:0]   gp_l_r, gp_r_r;

  logic signed [SW:0]       diff_l, diff_r;
  logic signed [P:0]        frac_s;
  logic signed [PROD_W-1:0] prod_l_nxt, prod_r_nxt;
  logic signed [ACC_W-1:0]  acc_l, acc_r;
  logic signed [SW-1:0]     s_l_nxt, s_r_nxt;
  logic signed [GP_W-1:0]   gp_l_nxt, gp_r_nxt;
  logic signed [OW-1:0]     g_l, g_r;

  assign step_wide = (WIDE_W'(pitch_r) << STEP_UP) >> STEP_DOWN;
  assign step      = step_wide[STEP_W-1:0];
  assign phase_sum = phase_r + PHASE_W'(step);

  assign sts.have_prev    = have_r;
  assign sts.phase_lt_one = (phase_r[PHASE_W-1:P] == '0);
  assign sts.next_lt_one  = (phase_sum[PHASE_W-1:P] == '0);
  assign sts.can_issue    = !va_r && !vb_r && !vc_r && (!out_valid || out_ready);

  // stage a: (cur - prev) * frac
  assign diff_l     = $signed({cur_l_r[SW-1], cur_l_r}) - $signed({prev_l_r[SW-1], prev_l_r});
  assign diff_r     = $signed({cur_r_r[SW-1], cur_r_r}) - $signed({prev_r_r[SW-1], prev_r_r});
  assign frac_s     = $signed({1'b0, phase_r[P-1:0]});
  assign prod_l_nxt = diff_l * frac_s;
  assign prod_r_nxt = diff_r * frac_s;

  // stage b: prev * one + product, truncated toward zero
  assign acc_l = $signed({{2{base_l_r[SW-1]}}, base_l_r, {P{1'b0}}}) + prod_l_r;
  assign acc_r = $signed({{2{base_r_r[SW-1]}}, base_r_r, {P{1'b0}}}) + prod_r_r;
  assign s_l_nxt = acc_l[P+SW-1:P] + SW'(acc_l[ACC_W-1] && (acc_l[P-1:0] != '0));
  assign s_r_nxt = acc_r[P+SW-1:P] + SW'(acc_r[ACC_W-1] && (acc_r[P-1:0] != '0));

  // stage c: times gain
  assign gp_l_nxt = s_l_r * $signed({1'b0, gain_r});
  assign gp_r_nxt = s_r_r * $signed({1'b0, gain_r});

  // gain scale, truncated toward zero
  assign g_l = gp_l_r[GS+OW-1:GS] + OW'(gp_l_r[GP_W-1] && (gp_l_r[GS-1:0] != '0));
  assign g_r = gp_r_r[GS+OW-1:GS] + OW'(gp_r_r[GP_W-1] && (gp_r_r[GS-1:0] != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r   <= slr_pkg::PITCH_RESET;
      gain_r    <= slr_pkg::GAIN_RESET;
      phase_r   <= '0;
      have_r    <= 1'b0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      vc_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          slr_pkg::CFG_PITCH_STEP: begin
            pitch_r <= cfg_wdata[slr_pkg::PITCH_W-1:0];
          end
          slr_pkg::CFG_VOLUME_GAIN: begin
            gain_r <= cfg_wdata[slr_pkg::GAIN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.take) begin
        have_r <= 1'b1;
        if (in_restart) begin
          phase_r <= '0;
        end
      end else if (cmd.issue) begin
        phase_r <= phase_sum;
      end else if (cmd.finish && !sts.phase_lt_one) begin
        phase_r <= phase_r - PHASE_ONE;
      end
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      // one result in flight at most, so the output register is free here
      if (vc_r) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_l_r <= in_left_in;
      cur_r_r <= in_right_in;
      if (in_restart || !have_r) begin
        prev_l_r <= in_left_in;
        prev_r_r <= in_right_in;
      end
    end else if (cmd.finish) begin
      prev_l_r <= cur_l_r;
      prev_r_r <= cur_r_r;
    end
    if (cmd.issue) begin
      prod_l_r <= prod_l_nxt;
      prod_r_r <= prod_r_nxt;
      base_l_r <= prev_l_r;
      base_r_r <= prev_r_r;
      last_a_r <= cmd.last;
    end
    s_l_r    <= s_l_nxt;
    s_r_r    <= s_r_nxt;
    last_b_r <= last_a_r;
    gp_l_r   <= gp_l_nxt;
    gp_r_r   <= gp_r_nxt;
    last_c_r <= last_b_r;
    if (vc_r) begin
      out_left_out    <= g_l;
      out_right_out   <= g_r;
      out_last_of_run <= last_c_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stereo_linear_resampler.sv
// Stereo linear-interpolation resampler. Each accepted source frame (two signed
// 16-bit samples) is interpolated against the frame before it at a fixed-point
// read phase; every output position between the two frames gives one result,
// truncated toward zero, scaled by the Q2.14 volume_gain (register 1) and
// truncated again, after which the phase moves by the Q4.16 pitch_step
// (register 0). Once a frame is accepted the block works on it alone: each
// result runs through a four-register arithmetic pipeline (interpolation
// multiply, truncation, gain multiply, output scale) and the next result is
// issued only once the previous one has left or is leaving the output
// register. A frame gives at most 16 results. The first frame after reset or
// a frame with restart set only primes the history and gives no result;
// last_of_run marks the final result of each frame. Write configuration only
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module stereo_linear_resampler #(
  parameter int PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [slr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] in_left_in,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] in_right_in,
  input  wire logic                                in_restart,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [slr_pkg::OUT_W-1:0]         out_left_out,
  output logic signed [slr_pkg::OUT_W-1:0]         out_right_out,
  output logic                                     out_last_of_run
);

  slr_pkg::slr_cmd_t cmd;
  slr_pkg::slr_sts_t sts;

  slr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  slr_datapath #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .in_restart      (in_restart),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// File: rtl/slr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_linear_resampler_assert.svh"

module slr_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                cfg_we,
  input wire logic [slr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input wire logic [slr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [slr_pkg::OUT_W-1:0]    out_left_out,
  input wire logic signed [slr_pkg::OUT_W-1:0]    out_right_out,
  input wire logic                                out_last_of_run
);

  logic                      out_fire;
  logic [slr_pkg::CNT_W-1:0] run_cnt_r;
  logic                      gain_zero_r;

  assign out_fire = out_valid && out_ready;

  // beats seen so far in the current run, and whether the gain is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r   <= '0;
      gain_zero_r <= 1'b0;
    end else begin
      if (out_fire) begin
        run_cnt_r <= out_last_of_run ? '0 : run_cnt_r + 1'b1;
      end
      if (cfg_we && (cfg_index == slr_pkg::CFG_VOLUME_GAIN)) begin
        gain_zero_r <= (cfg_wdata[slr_pkg::GAIN_W-1:0] == '0);
      end
    end
  end

  `SLR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_left_out) && $stable(out_right_out) && $stable(out_last_of_run))
  `SLR_ASSERT_NOW(a_run_len, clk, rst_n, out_fire, run_cnt_r < slr_pkg::CNT_W'(slr_pkg::MAX_OUT))
  `SLR_ASSERT_NOW(a_gain_zero, clk, rst_n, out_fire && gain_zero_r, (out_left_out == '0) && (out_right_out == '0))

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_we          (cfg_we),
  .cfg_index       (cfg_index),
  .cfg_wdata       (cfg_wdata),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_left_out    (out_left_out),
  .out_right_out   (out_right_out),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic signed [slr_pkg::SAMPLE_W-1:0] left;
    logic signed [slr_pkg::SAMPLE_W-1:0] right;
    logic                                restart;
  } frame_t;

  typedef struct packed {
    logic signed [slr_pkg::OUT_W-1:0] left;
    logic signed [slr_pkg::OUT_W-1:0] right;
    logic                             last;
  } pair_t;

  localparam logic [20:0] PHASE_ONE     = 21'h10000;
  localparam int          SETTLE_CYCLES = 80;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PRESSURE_PHASE = 6;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [slr_pkg::CFG_IDX_W-1:0]       cfg_index = slr_pkg::CFG_PITCH_STEP;
  logic [slr_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [slr_pkg::SAMPLE_W-1:0] in_left_in = '0;
  logic signed [slr_pkg::SAMPLE_W-1:0] in_right_in = '0;
  logic                                in_restart = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [slr_pkg::OUT_W-1:0]    out_left_out;
  logic signed [slr_pkg::OUT_W-1:0]    out_right_out;
  logic                                out_last_of_run;

  frame_t pending_frames[$];
  pair_t  expected_pairs[$];
  frame_t next_frame;
  pair_t  oldest_pair;

  // resampler state as the bench sees it
  logic [slr_pkg::PITCH_W-1:0]         pitch_q = slr_pkg::PITCH_RESET;
  logic [slr_pkg::GAIN_W-1:0]          gain_q = slr_pkg::GAIN_RESET;
  logic signed [slr_pkg::SAMPLE_W-1:0] hist_left = '0;
  logic signed [slr_pkg::SAMPLE_W-1:0] hist_right = '0;
  logic [20:0]                         read_pos = '0;
  logic                                primed = 1'b0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int   phase_num = 0;
  int   error_count = 0;

  stereo_linear_resampler dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_in     (in_left_in),
    .in_right_in    (in_right_in),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_out   (out_left_out),
    .out_right_out  (out_right_out),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // interpolate, truncate toward zero, apply gain, truncate again
  function automatic logic signed [slr_pkg::OUT_W-1:0] blend(
      input logic signed [slr_pkg::SAMPLE_W-1:0] a,
      input logic signed [slr_pkg::SAMPLE_W-1:0] b,
      input logic [15:0] frac);
    longint acc;
    longint s;
    longint g;
    acc = longint'(a) * (longint'(65536) - longint'(frac)) + longint'(b) * longint'(frac);
    s = acc / 65536;
    g = (s * longint'(gain_q)) / 16384;
    return g[slr_pkg::OUT_W-1:0];
  endfunction

  task automatic predict_frame(input frame_t f);
    pair_t       p;
    logic [20:0] nxt;
    int          n;
    if (f.restart) begin
      read_pos = '0;
      primed = 1'b0;
    end
    if (!primed) begin
      hist_left = f.left;
      hist_right = f.right;
      primed = 1'b1;
      return;
    end
    n = 0;
    while (n < slr_pkg::MAX_OUT && read_pos < PHASE_ONE) begin
      nxt = read_pos + 21'(pitch_q);
      p.left = blend(hist_left, f.left, read_pos[15:0]);
      p.right = blend(hist_right, f.right, read_pos[15:0]);
      p.last = (n == slr_pkg::MAX_OUT - 1) || (nxt >= PHASE_ONE);
      expected_pairs.push_back(p);
      read_pos = nxt;
      n++;
    end
    // below one frame after a capped run the fraction carries over
    if (read_pos >= PHASE_ONE) begin
      read_pos = read_pos - PHASE_ONE;
    end
    hist_left = f.left;
    hist_right = f.right;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      predict_frame({in_left_in, in_right_in, in_restart});
    end
    if (rst_n && (!in_valid || in_ready)) begin
      if (pending_frames.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_frame = pending_frames.pop_front();
        in_valid <= 1'b1;
        in_left_in <= next_frame.left;
        in_right_in <= next_frame.right;
        in_restart <= next_frame.restart;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("result beat with nothing expected, left_out", out_left_out, 0);
      end else begin
        oldest_pair = expected_pairs.pop_front();
        if (out_left_out !== oldest_pair.left)
          report_mismatch("left_out", out_left_out, oldest_pair.left);
        if (out_right_out !== oldest_pair.right)
          report_mismatch("right_out", out_right_out, oldest_pair.right);
        if (out_last_of_run !== oldest_pair.last)
          report_mismatch("last_of_run", out_last_of_run, oldest_pair.last);
      end
    end
    out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (phase_num == PRESSURE_PHASE);
    repeat (20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic write_reg(input logic [slr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == slr_pkg::CFG_PITCH_STEP) begin
      pitch_q = val;
    end else begin
      gain_q = val[slr_pkg::GAIN_W-1:0];
    end
  endtask

  task automatic set_config(input int pitch, input int gain, input int sidle, input int rstall);
    write_reg(slr_pkg::CFG_PITCH_STEP, 20'(pitch));
    write_reg(slr_pkg::CFG_VOLUME_GAIN, 20'(gain));
    send_idle_pct <= sidle;
    recv_stall_pct <= rstall;
  endtask

  task automatic push_frame(input int l, input int r, input logic rs);
    frame_t f;
    f.left = 16'(l);
    f.right = 16'(r);
    f.restart = rs;
    pending_frames.push_back(f);
  endtask

  function automatic logic signed [slr_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int pick_pitch();
    case ($urandom_range(0, 5))
      0: return 4096;
      1: return $urandom_range(98304, 1048575);
      default: return $urandom_range(4096, 98304);
    endcase
  endfunction

  task automatic add_random(input int count);
    frame_t f;
    repeat (count) begin
      f.left = pick_sample();
      f.right = pick_sample();
      f.restart = ($urandom_range(0, 29) == 0);
      pending_frames.push_back(f);
    end
  endtask

  // no pending frame, no beat in flight, then let the pipeline settle
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_frames.size() != 0 || in_valid || expected_pairs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: priming frame, full-scale swings, restart
    phase_num = 1;
    push_frame(0, 0, 1'b0);
    push_frame(32767, -32768, 1'b0);
    push_frame(-32768, 32767, 1'b0);
    push_frame(-1, 1, 1'b0);
    push_frame(100, -100, 1'b1);
    push_frame(32767, 32767, 1'b0);
    wait_idle();

    // smallest legal step with full gain: sixteen results per frame
    phase_num = 2;
    set_config(4096, 65535, 0, 0);
    push_frame(-32768, -32768, 1'b1);
    push_frame(32767, 32767, 1'b0);
    push_frame(-32768, 32767, 1'b0);
    push_frame(0, -1, 1'b0);
    wait_idle();

    // largest step with zero gain: frames get skipped
    phase_num = 3;
    set_config(1048575, 0, 0, 0);
    push_frame(1234, -4321, 1'b0);
    push_frame(-32768, 32767, 1'b0);
    push_frame(5, 5, 1'b0);
    push_frame(32767, -32768, 1'b0);
    push_frame(-7, 7, 1'b0);
    wait_idle();

    // step below the cap limit: fraction carries across frames
    phase_num = 4;
    set_config(1000, 16384, 0, 0);
    push_frame(-20000, 20000, 1'b1);
    push_frame(20000, -20000, 1'b0);
    push_frame(32767, -32768, 1'b0);
    push_frame(-32768, 32767, 1'b0);
    wait_idle();

    phase_num = 5;
    set_config(pick_pitch(), $urandom_range(0, 65535), 0, 0);
    add_random(90);
    wait_idle();

    phase_num = PRESSURE_PHASE;
    set_config(8192, 20000, 0, 0);
    add_random(80);
    wait_idle();

    phase_num = 7;
    set_config(pick_pitch(), $urandom_range(0, 65535), 66, 0);
    add_random(70);
    wait_idle();

    phase_num = 8;
    set_config(pick_pitch(), $urandom_range(0, 65535), 0, 66);
    add_random(70);
    wait_idle();

    phase_num = 9;
    set_config(4096, $urandom_range(0, 65535), 21, 21);
    add_random(60);
    wait_idle();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
